// ===== sv/sorted_key_value_table_top_macros.svh =====
// Assertion macros for the table's top-level RTL.
`ifndef SORTED_KEY_VALUE_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_VALUE_TABLE_TOP_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define SKVT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication, checked on every rising edge outside reset.
`define SKVT_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== sv/skvt_pkg.sv =====
package skvt_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned TotalW   = 7;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [2:0] ReqInsert      = 3'd0;
  localparam logic [2:0] ReqLookup      = 3'd1;
  localparam logic [2:0] ReqRemove      = 3'd2;
  localparam logic [2:0] ReqIterReset   = 3'd3;
  localparam logic [2:0] ReqIterRead    = 3'd4;
  localparam logic [2:0] ReqIterAdvance = 3'd5;

  typedef enum logic [2:0] {
    OpInsert,
    OpLookup,
    OpRemove,
    OpIterReset,
    OpIterRead,
    OpIterAdvance,
    OpNone
  } op_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] key;
    logic [31:0]        value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [31:0]        value_out;
    logic signed [31:0] key_out;
    logic               at_end;
    logic [TotalW-1:0]  entry_total;
    logic               full_refused;
  } rsp_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] key;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
  } entry_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic [CntW-1:0] iter;
  } status_t;

  // Signed order of two key words, done as an unsigned compare with the sign bit flipped.
  function automatic logic key_below(logic [31:0] a, logic [31:0] b);
    return {~a[31], a[30:0]} < {~b[31], b[30:0]};
  endfunction

endpackage

// ===== sv/skvt_ram.sv =====
module skvt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/skvt_front.sv =====
module skvt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  skvt_pkg::req_t    req_i,
  output logic              queue_full_o,
  output logic              cmd_valid_o,
  output skvt_pkg::cmd_t    cmd_o,
  input  logic              cmd_ready_i
);

  skvt_pkg::cmd_t                  queue_q [skvt_pkg::QDepth];
  logic [skvt_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [skvt_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [skvt_pkg::QCntW-1:0]      fill_q, fill_d;
  skvt_pkg::cmd_t                  cmd_in;
  logic                            do_push;
  logic                            do_pop;

  // Sort the request code into an operation; codes without meaning become a no-op.
  always_comb begin
    cmd_in.key   = req_i.key;
    cmd_in.value = req_i.value;
    unique case (req_i.req_type)
      skvt_pkg::ReqInsert:      cmd_in.op = skvt_pkg::OpInsert;
      skvt_pkg::ReqLookup:      cmd_in.op = skvt_pkg::OpLookup;
      skvt_pkg::ReqRemove:      cmd_in.op = skvt_pkg::OpRemove;
      skvt_pkg::ReqIterReset:   cmd_in.op = skvt_pkg::OpIterReset;
      skvt_pkg::ReqIterRead:    cmd_in.op = skvt_pkg::OpIterRead;
      skvt_pkg::ReqIterAdvance: cmd_in.op = skvt_pkg::OpIterAdvance;
      default:                  cmd_in.op = skvt_pkg::OpNone;
    endcase
  end

  assign queue_full_o = (fill_q == skvt_pkg::QCntW'(skvt_pkg::QDepth));
  assign cmd_valid_o  = (fill_q != '0);
  assign cmd_o        = queue_q[rd_ptr_q];
  assign do_push      = push_i && !queue_full_o;
  assign do_pop       = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == skvt_pkg::QPtrW'(skvt_pkg::QDepth - 1)) ? '0
               : wr_ptr_q + skvt_pkg::QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == skvt_pkg::QPtrW'(skvt_pkg::QDepth - 1)) ? '0
               : rd_ptr_q + skvt_pkg::QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + skvt_pkg::QCntW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - skvt_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== sv/skvt_back.sv =====
module skvt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  skvt_pkg::cmd_t    cmd_i,
  output logic              cmd_ready_o,
  output logic              rsp_valid_o,
  output skvt_pkg::rsp_t    rsp_o,
  input  logic              rsp_pop_i,
  output skvt_pkg::status_t status_o
);

  localparam int unsigned CntW = skvt_pkg::CntW;
  localparam int unsigned IdxW = skvt_pkg::IdxW;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSrch  = 4'd1;
  localparam logic [3:0] StCmp   = 4'd2;
  localparam logic [3:0] StDec   = 4'd3;
  localparam logic [3:0] StShRd  = 4'd4;
  localparam logic [3:0] StShWr  = 4'd5;
  localparam logic [3:0] StInsWr = 4'd6;
  localparam logic [3:0] StRmRd  = 4'd7;
  localparam logic [3:0] StRmWr  = 4'd8;
  localparam logic [3:0] StIRd   = 4'd9;
  localparam logic [3:0] StResp  = 4'd10;

  logic [3:0]       state_q, state_d;
  skvt_pkg::cmd_t   cmd_q, cmd_d;
  logic [CntW-1:0]  lo_q, lo_d;
  logic [CntW-1:0]  hi_q, hi_d;
  logic [CntW-1:0]  mid_q, mid_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             hit_q, hit_d;
  logic [31:0]      vout_q, vout_d;
  logic [31:0]      kout_q, kout_d;
  logic             refused_q, refused_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  iter_q, iter_d;
  skvt_pkg::rsp_t   rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;

  logic [CntW:0]    mid_sum;
  logic [CntW-1:0]  mid;
  logic [CntW-1:0]  idx_next;
  logic [CntW-1:0]  iter_next;

  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr;
  skvt_pkg::entry_t       ram_wdata;
  logic [IdxW-1:0]        ram_raddr;
  skvt_pkg::entry_t       ram_rdata;

  skvt_ram #(
    .Width($bits(skvt_pkg::entry_t)),
    .Depth(skvt_pkg::Capacity)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[CntW:1];
  assign idx_next  = CntW'(idx_q) + CntW'(1);
  assign iter_next = iter_q + CntW'(1);

  assign cmd_ready_o = (state_q == StIdle);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign status_o    = '{count: count_q, iter: iter_q};

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    vout_d      = vout_q;
    kout_d      = kout_q;
    refused_d   = refused_q;
    count_d     = count_q;
    iter_d      = iter_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = mid[IdxW-1:0];

    if (rsp_valid_q && rsp_pop_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_d     = cmd_i;
          lo_d      = '0;
          hi_d      = count_q;
          hit_d     = 1'b0;
          vout_d    = '0;
          kout_d    = '0;
          refused_d = 1'b0;
          state_d   = StResp;
          unique case (cmd_i.op)
            skvt_pkg::OpInsert, skvt_pkg::OpLookup, skvt_pkg::OpRemove: begin
              state_d = StSrch;
            end
            skvt_pkg::OpIterReset: begin
              iter_d = (count_q != '0) ? '0 : CntW'(skvt_pkg::Capacity);
            end
            skvt_pkg::OpIterAdvance: begin
              if (iter_q < count_q) begin
                iter_d = (iter_next >= count_q) ? CntW'(skvt_pkg::Capacity) : iter_next;
              end
            end
            skvt_pkg::OpIterRead: begin
              if (iter_q < count_q) begin
                ram_raddr = iter_q[IdxW-1:0];
                state_d   = StIRd;
              end
            end
            default: begin
              state_d = StResp;
            end
          endcase
        end
      end

      // Binary search for the first entry whose key is not below the request key.
      StSrch: begin
        if (lo_q < hi_q) begin
          ram_raddr = mid[IdxW-1:0];
          mid_d     = mid;
          state_d   = StCmp;
        end else begin
          state_d = StDec;
        end
      end

      StCmp: begin
        if (skvt_pkg::key_below(ram_rdata.key, cmd_q.key)) begin
          lo_d = mid_q + CntW'(1);
        end else begin
          // The last entry that lowered the upper bound is the one at the final position.
          hi_d   = mid_q;
          hit_d  = (ram_rdata.key == cmd_q.key);
          vout_d = (ram_rdata.key == cmd_q.key) ? ram_rdata.value : '0;
        end
        state_d = StSrch;
      end

      StDec: begin
        if (cmd_q.op != skvt_pkg::OpLookup) begin
          vout_d = '0;
        end
        state_d = StResp;
        if (cmd_q.op == skvt_pkg::OpInsert) begin
          if (hit_q) begin
            state_d = StInsWr;
          end else if (count_q >= CntW'(skvt_pkg::Capacity)) begin
            refused_d = 1'b1;
          end else begin
            idx_d   = count_q[IdxW-1:0];
            state_d = (count_q > hi_q) ? StShRd : StInsWr;
          end
        end else if (cmd_q.op == skvt_pkg::OpRemove && hit_q) begin
          idx_d   = hi_q[IdxW-1:0];
          state_d = StRmRd;
        end
      end

      StShRd: begin
        ram_raddr = idx_q - IdxW'(1);
        state_d   = StShWr;
      end

      StShWr: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        idx_d     = idx_q - IdxW'(1);
        state_d   = (CntW'(idx_q - IdxW'(1)) > hi_q) ? StShRd : StInsWr;
      end

      StInsWr: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q[IdxW-1:0];
        ram_wdata = '{key: cmd_q.key, value: cmd_q.value};
        if (!hit_q) begin
          count_d = count_q + CntW'(1);
        end
        state_d = StResp;
      end

      StRmRd: begin
        if (idx_next < count_q) begin
          ram_raddr = idx_next[IdxW-1:0];
          state_d   = StRmWr;
        end else begin
          count_d = count_q - CntW'(1);
          state_d = StResp;
        end
      end

      StRmWr: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        idx_d     = idx_next[IdxW-1:0];
        state_d   = StRmRd;
      end

      StIRd: begin
        kout_d  = ram_rdata.key;
        vout_d  = ram_rdata.value;
        state_d = StResp;
      end

      StResp: begin
        if (!rsp_valid_q || rsp_pop_i) begin
          rsp_d.found        = hit_q;
          rsp_d.value_out    = vout_q;
          rsp_d.key_out      = kout_q;
          rsp_d.at_end       = (iter_q >= count_q);
          rsp_d.entry_total  = skvt_pkg::TotalW'(count_q);
          rsp_d.full_refused = refused_q;
          rsp_valid_d        = 1'b1;
          state_d            = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      iter_q      <= CntW'(skvt_pkg::Capacity);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      iter_q      <= iter_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    idx_q     <= idx_d;
    hit_q     <= hit_d;
    vout_q    <= vout_d;
    kout_q    <= kout_d;
    refused_q <= refused_d;
    rsp_q     <= rsp_d;
  end

endmodule

// ===== sv/sorted_key_value_table_top.sv =====
// Operation: a lookup, insert or remove first runs a binary search over the entries; a new key
// is then inserted by shifting the later entries up, an insert that hits overwrites the value,
// a remove that hits shifts the later entries down. The back end takes a new request only when
// idle, held by the search and shift loop over the single-read-port entry RAM and by a result
// that waits; a two-entry request queue buffers meanwhile.
// Reset (asynchronous, active low) empties the table and puts the iterator at end; no RAM clear.
`include "sorted_key_value_table_top_macros.svh"

module sorted_key_value_table_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  skvt_pkg::req_t req_i,
  output logic           empty,
  input  logic           pop,
  output skvt_pkg::rsp_t rsp_o
);

  logic              cmd_valid;
  logic              cmd_ready;
  skvt_pkg::cmd_t    cmd;
  logic              rsp_valid;
  skvt_pkg::status_t status;

  skvt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (req_i),
    .queue_full_o(full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  skvt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_ready_o(cmd_ready),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp_o),
    .rsp_pop_i  (pop),
    .status_o   (status)
  );

  assign empty = !rsp_valid;

  `SKVT_ASSERT(count_bound_a, clk_i, rst_ni,
    status.count <= skvt_pkg::CntW'(skvt_pkg::Capacity), "entry count above capacity")
  `SKVT_ASSERT(iter_bound_a, clk_i, rst_ni,
    status.iter <= skvt_pkg::CntW'(skvt_pkg::Capacity), "iterator beyond end marker")
  `SKVT_ASSERT(count_step_a, clk_i, rst_ni,
    (status.count == $past(status.count)) ||
    (status.count == $past(status.count) + skvt_pkg::CntW'(1)) ||
    (status.count + skvt_pkg::CntW'(1) == $past(status.count)),
    "entry count moved by more than one")
  `SKVT_ASSERT_IMP(take_idle_a, clk_i, rst_ni, cmd_valid && cmd_ready,
    $stable(status.count), "request taken while the table was changing")

endmodule

// ===== verif/sorted_key_value_table_top_test.sv =====
`timescale 1ns / 100ps

module sorted_key_value_table_top_test;
  import skvt_pkg::*;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TailCycles = 200;
  localparam int unsigned PoolSize   = 80;
  localparam int unsigned MixItems   = 350;
  localparam int unsigned QuietItems = 100;
  localparam int unsigned DirRows    = 24;

  // Request codes that the block does not define; it only reports status for them.
  localparam logic [2:0] ReqUnusedLo = 3'd6;
  localparam logic [2:0] ReqUnusedHi = 3'd7;

  localparam logic [31:0] KeyMin = 32'h8000_0000;
  localparam logic [31:0] KeyMax = 32'h7FFF_FFFF;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  req_t req_i = '0;
  logic empty;
  logic pop = 1'b0;
  rsp_t rsp_o;

  // Shadow copy of the table contents and iterator.
  logic signed [31:0] tbl_keys [Capacity];
  logic [31:0]        tbl_vals [Capacity];
  int unsigned        tbl_count = 0;
  int unsigned        tbl_iter  = Capacity;

  rsp_t               pending_rsps [$];
  logic signed [31:0] key_pool [PoolSize];
  dir_row_t           dir_rows [DirRows];

  int unsigned err_count   = 0;
  int unsigned rsp_seen    = 0;
  int unsigned cycle_count = 0;
  bit          quiet       = 1'b0;
  int unsigned stall_left  = 0;

  sorted_key_value_table_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .req_i  (req_i),
    .empty  (empty),
    .pop    (pop),
    .rsp_o  (rsp_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_rsps.size());
      $display("sorted_key_value_table_top_test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got 0x%08h expected 0x%08h",
                                rsp_seen, name, got, want));
    end
  endtask

  // Applies one request to the shadow table and returns the response it must give.
  function automatic rsp_t table_step(input req_t r);
    rsp_t        res;
    int unsigned pos;
    int unsigned i;
    bit          hit;
    res = '0;
    pos = 0;
    while (pos < tbl_count && tbl_keys[pos] < $signed(r.key)) pos++;
    hit = (pos < tbl_count) && (tbl_keys[pos] == $signed(r.key));
    case (r.req_type)
      ReqInsert: begin
        if (hit) begin
          tbl_vals[pos] = r.value;
          res.found = 1'b1;
        end else if (tbl_count >= Capacity) begin
          res.full_refused = 1'b1;
        end else begin
          for (i = tbl_count; i > pos; i--) begin
            tbl_keys[i] = tbl_keys[i - 1];
            tbl_vals[i] = tbl_vals[i - 1];
          end
          tbl_keys[pos] = r.key;
          tbl_vals[pos] = r.value;
          tbl_count++;
        end
      end
      ReqLookup: begin
        if (hit) begin
          res.found     = 1'b1;
          res.value_out = tbl_vals[pos];
        end
      end
      ReqRemove: begin
        if (hit) begin
          res.found = 1'b1;
          for (i = pos; i + 1 < tbl_count; i++) begin
            tbl_keys[i] = tbl_keys[i + 1];
            tbl_vals[i] = tbl_vals[i + 1];
          end
          tbl_count--;
        end
      end
      ReqIterReset: tbl_iter = (tbl_count > 0) ? 0 : Capacity;
      ReqIterRead: begin
        if (tbl_iter < tbl_count) begin
          res.key_out   = tbl_keys[tbl_iter];
          res.value_out = tbl_vals[tbl_iter];
        end
      end
      ReqIterAdvance: begin
        if (tbl_iter < tbl_count) begin
          tbl_iter++;
          if (tbl_iter >= tbl_count) tbl_iter = Capacity;
        end
      end
      default: ;
    endcase
    res.at_end      = (tbl_iter >= tbl_count);
    res.entry_total = tbl_count[TotalW-1:0];
    return res;
  endfunction

  function automatic req_t mk_req(input logic [2:0] code, input logic [31:0] key,
                                  input logic [31:0] value);
    req_t r;
    r.req_type = code;
    r.key      = key;
    r.value    = value;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input bit found, input logic [31:0] vout,
                                  input logic [31:0] kout, input bit at_end,
                                  input int unsigned total, input bit refused);
    rsp_t s;
    s.found        = found;
    s.value_out    = vout;
    s.key_out      = kout;
    s.at_end       = at_end;
    s.entry_total  = total[TotalW-1:0];
    s.full_refused = refused;
    return s;
  endfunction

  // Mostly keys from a small pool so that lookups and removes hit.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom();
  endfunction

  function automatic req_t random_req(input bit drain_bias);
    req_t        r;
    int unsigned roll;
    int unsigned ins_top;
    int unsigned look_top;
    r.key    = pick_key();
    r.value  = $urandom();
    roll     = $urandom_range(0, 99);
    ins_top  = drain_bias ? 10 : 35;
    look_top = drain_bias ? 25 : 55;
    if (roll < ins_top) r.req_type = ReqInsert;
    else if (roll < look_top) r.req_type = ReqLookup;
    else if (roll < 68) r.req_type = ReqRemove;
    else if (roll < 74) r.req_type = ReqIterReset;
    else if (roll < 86) r.req_type = ReqIterRead;
    else if (roll < 97) r.req_type = ReqIterAdvance;
    else r.req_type = $urandom_range(0, 1) ? ReqUnusedLo : ReqUnusedHi;
    return r;
  endfunction

  // Holds the request until the transfer, then files the expected response.
  task automatic send_req(input req_t r, input bit typed, input rsp_t want);
    rsp_t pred;
    push  <= 1'b1;
    req_i <= r;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    pred = table_step(r);
    pending_rsps.push_back(typed ? want : pred);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Always spends at least one edge so that push is not driven twice in one step.
  task automatic drain_then_resume();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_rsps.size() != 0);
  endtask

  task automatic send_random(input req_t r);
    send_req(r, 1'b0, '0);
    sender_gap();
  endtask

  // Response side: checks each transfer and stalls in random bursts.
  initial begin
    rsp_t want;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_rsps.size() == 0) begin
          report_mismatch($sformatf("unexpected result 0x%0h", rsp_o));
        end else begin
          want = pending_rsps.pop_front();
          check_field("found", rsp_o.found, want.found);
          check_field("value_out", rsp_o.value_out, want.value_out);
          check_field("key_out", rsp_o.key_out, want.key_out);
          check_field("at_end", rsp_o.at_end, want.at_end);
          check_field("entry_total", rsp_o.entry_total, want.entry_total);
          check_field("full_refused", rsp_o.full_refused, want.full_refused);
        end
        rsp_seen++;
      end
      if (!rst_ni) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 18);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned n;
    req_t        r;

    key_pool[0] = KeyMin;
    key_pool[1] = KeyMax;
    key_pool[2] = 32'd0;
    key_pool[3] = 32'hFFFF_FFFF;
    for (i = 4; i < PoolSize; i++) key_pool[i] = $urandom();

    dir_rows = '{
      '{mk_req(ReqLookup, 32'd0, 32'd0), 1'b1, mk_rsp(0, 0, 0, 1, 0, 0)},
      '{mk_req(ReqIterRead, 32'd0, 32'd0), 1'b1, mk_rsp(0, 0, 0, 1, 0, 0)},
      '{mk_req(ReqIterReset, 32'd0, 32'd0), 1'b1, mk_rsp(0, 0, 0, 1, 0, 0)},
      '{mk_req(ReqIterAdvance, 32'd0, 32'd0), 1'b1, mk_rsp(0, 0, 0, 1, 0, 0)},
      '{mk_req(ReqRemove, 32'd5, 32'd0), 1'b1, mk_rsp(0, 0, 0, 1, 0, 0)},
      '{mk_req(ReqUnusedLo, '1, '1), 1'b1, mk_rsp(0, 0, 0, 1, 0, 0)},
      '{mk_req(ReqUnusedHi, '1, '1), 1'b1, mk_rsp(0, 0, 0, 1, 0, 0)},
      '{mk_req(ReqInsert, KeyMin, '1), 1'b1, mk_rsp(0, 0, 0, 1, 1, 0)},
      '{mk_req(ReqInsert, KeyMax, 32'd0), 1'b1, mk_rsp(0, 0, 0, 1, 2, 0)},
      '{mk_req(ReqInsert, 32'd0, 32'hA5A5_A5A5), 1'b1, mk_rsp(0, 0, 0, 1, 3, 0)},
      '{mk_req(ReqInsert, 32'd0, 32'h5A5A_5A5A), 1'b1, mk_rsp(1, 0, 0, 1, 3, 0)},
      '{mk_req(ReqLookup, 32'd0, 32'd0), 1'b1, mk_rsp(1, 32'h5A5A_5A5A, 0, 1, 3, 0)},
      '{mk_req(ReqLookup, '1, 32'd0), 1'b1, mk_rsp(0, 0, 0, 1, 3, 0)},
      '{mk_req(ReqIterReset, 32'd0, 32'd0), 1'b1, mk_rsp(0, 0, 0, 0, 3, 0)},
      '{mk_req(ReqIterRead, 32'd0, 32'd0), 1'b1, mk_rsp(0, '1, KeyMin, 0, 3, 0)},
      '{mk_req(ReqIterAdvance, 32'd0, 32'd0), 1'b0, '0},
      '{mk_req(ReqIterRead, 32'd0, 32'd0), 1'b0, '0},
      '{mk_req(ReqIterAdvance, 32'd0, 32'd0), 1'b0, '0},
      '{mk_req(ReqIterRead, 32'd0, 32'd0), 1'b1, mk_rsp(0, 0, KeyMax, 0, 3, 0)},
      '{mk_req(ReqIterAdvance, 32'd0, 32'd0), 1'b1, mk_rsp(0, 0, 0, 1, 3, 0)},
      '{mk_req(ReqIterRead, 32'd0, 32'd0), 1'b1, mk_rsp(0, 0, 0, 1, 3, 0)},
      '{mk_req(ReqRemove, KeyMax, 32'd0), 1'b1, mk_rsp(1, 0, 0, 1, 2, 0)},
      '{mk_req(ReqRemove, KeyMin, 32'd0), 1'b1, mk_rsp(1, 0, 0, 1, 1, 0)},
      '{mk_req(ReqLookup, KeyMin, 32'd0), 1'b1, mk_rsp(0, 0, 0, 1, 1, 0)}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DirRows; i++) begin
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      sender_gap();
    end
    drain_then_resume();

    // Fill the table past its capacity so that new keys are refused.
    for (i = 0; i < PoolSize; i++) begin
      send_random(mk_req(ReqInsert, key_pool[i], $urandom()));
    end
    for (i = 0; i < 4; i++) send_random(mk_req(ReqInsert, $urandom(), $urandom()));
    drain_then_resume();

    // Walk the iterator over the table, now and then changing the table underneath it.
    send_random(mk_req(ReqIterReset, $urandom(), $urandom()));
    for (i = 0; i < Capacity + 2; i++) begin
      send_random(mk_req(ReqIterRead, $urandom(), $urandom()));
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(0, 1);
        send_random(mk_req(n ? ReqRemove : ReqInsert, pick_key(), $urandom()));
      end
      send_random(mk_req(ReqIterAdvance, $urandom(), $urandom()));
    end

    // Mixed traffic, alternating between growing and draining the table.
    for (i = 0; i < MixItems; i++) begin
      if (i >= MixItems - QuietItems) quiet = 1'b1;
      r = random_req((i / 100) % 2 == 1);
      send_random(r);
    end
    push <= 1'b0;

    while (pending_rsps.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (err_count == 0 && pending_rsps.size() == 0) begin
      $display("sorted_key_value_table_top_test passed");
    end else begin
      $display("sorted_key_value_table_top_test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/skvt_pkg.sv
sv/skvt_ram.sv
sv/skvt_front.sv
sv/skvt_back.sv
sv/sorted_key_value_table_top.sv
verif/sorted_key_value_table_top_test.sv
